// ===== rtl/atmc_pkg.sv =====
// Shared types and character constants for the AT motion command parser.
`timescale 1ns / 1ps
package atmc_pkg;

    // Width of the line length counter; holds the largest allowed line limit
    localparam int LEN_W          = 8;
    localparam int LINE_MIN_TOTAL = 4;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // Command names, older character in the high byte
    localparam logic [15:0] NAME_GF = 16'h4746;
    localparam logic [15:0] NAME_GB = 16'h4742;
    localparam logic [15:0] NAME_GR = 16'h4752;
    localparam logic [15:0] NAME_GL = 16'h474C;
    localparam logic [15:0] NAME_ST = 16'h5354;

    // Result kinds
    localparam logic [2:0] KIND_HEARTBEAT = 3'd0;
    localparam logic [2:0] KIND_FORWARD   = 3'd1;
    localparam logic [2:0] KIND_BACK      = 3'd2;
    localparam logic [2:0] KIND_RIGHT     = 3'd3;
    localparam logic [2:0] KIND_LEFT      = 3'd4;
    localparam logic [2:0] KIND_STOP      = 3'd5;

    // Parse phase of the current line
    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_NAME,
        PH_ARG_WAIT,
        PH_ARG_IN,
        PH_ARG_DONE
    } t_phase;

    // Classified word handed from the front to the back
    typedef struct packed {
        logic       eol;       // CR LF seen: finish the line
        logic       feed_cr;   // held CR turned out to be a line byte
        logic       feed_b;    // the byte itself is a line byte
        logic       is_digit;
        logic       is_eq;
        logic       is_comma;
        logic [7:0] data;
    } t_token;

    // One decoded command
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] power;
    } t_result;

    // Line parse state
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             ovf;
        logic             prefix_ok;
        t_phase           phase;
        logic [15:0]      name;
        logic [7:0]       ncount;
        logic [15:0]      value;
        logic             bad;
    } t_parse;

    localparam t_parse PARSE_CLEAR = '{
        len:       '0,
        ovf:       1'b0,
        prefix_ok: 1'b1,
        phase:     PH_PREFIX,
        name:      '0,
        ncount:    '0,
        value:     '0,
        bad:       1'b0
    };

endpackage

// ===== rtl/at_motion_command_parser.sv =====
// Top level of the AT motion command parser.
// Throughput: one byte per cycle; full rises only when the four-word queue
// between front and back fills, which happens while the result queue is full.
// Path: the LF word is written into the token queue, and the back decodes it
// from there into the result queue once that queue has room.
// Reset: synchronous active-low i_rst_n empties both queues and clears
// the held CR and all line state; no clearing pass is needed.
`timescale 1ns / 1ps
module at_motion_command_parser
    import atmc_pkg::*;
#(
    parameter int MAX_LINE  = 64,
    parameter int TOK_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_command_kind,
    output logic [15:0] o_power
);

    localparam int TOK_W = $bits(t_token);
    localparam int RES_W = $bits(t_result);

    logic             accept;
    logic             tok_wr;
    t_token           tok_in;
    logic [TOK_W-1:0] tok_raw;
    logic             tok_empty;
    logic             tok_pop;
    logic             res_full;
    logic             res_push;
    t_result          res_in;
    logic [RES_W-1:0] res_raw;
    t_result          res_out;

    assign accept = push && !full;

    // Classify incoming bytes
    atmc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_tok_wr  (tok_wr),
        .o_tok     (tok_in)
    );

    // Decouple front and back
    atmc_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (TOK_DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (tok_wr),
        .i_wdata (tok_in),
        .o_full  (full),
        .i_rd    (tok_pop),
        .o_rdata (tok_raw),
        .o_empty (tok_empty)
    );

    // Parse lines and decode commands
    atmc_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!tok_empty),
        .i_tok       (t_token'(tok_raw)),
        .o_tok_pop   (tok_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Hold results for the consumer
    atmc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_raw),
        .o_empty (empty)
    );

    assign res_out        = t_result'(res_raw);
    assign o_command_kind = res_out.kind;
    assign o_power        = res_out.power;

endmodule

// ===== rtl/atmc_fifo.sv =====
// Small first-word-fall-through queue used between the parser stages and to hold results.
`timescale 1ns / 1ps
module atmc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    // Advance pointers and occupancy
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (wr_en) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_en) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy above depth");

endmodule

// ===== rtl/atmc_front.sv =====
// Front stage: CR LF detection and byte classification.
`timescale 1ns / 1ps
module atmc_front
    import atmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_tok_wr,
    output t_token     o_tok
);

    logic r_pending, n_pending;
    logic is_cr, is_lf;

    assign is_cr = (i_rx_byte == CH_CR);
    assign is_lf = (i_rx_byte == CH_LF);

    // Build the word for the back stage
    always_comb begin
        o_tok.eol      = r_pending && is_lf;
        o_tok.feed_cr  = r_pending && !is_lf;
        o_tok.feed_b   = !is_cr && !(r_pending && is_lf);
        o_tok.is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
        o_tok.is_eq    = (i_rx_byte == CH_EQ);
        o_tok.is_comma = (i_rx_byte == CH_COMMA);
        o_tok.data     = i_rx_byte;
        o_tok_wr       = i_accept && (o_tok.eol || o_tok.feed_cr || o_tok.feed_b);
    end

    // Hold a CR until the next byte says whether it ends the line
    always_comb begin
        n_pending = r_pending;
        if (i_accept) begin
            n_pending = !(r_pending && is_lf) && is_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else begin
            r_pending <= n_pending;
        end
    end

endmodule

// ===== rtl/atmc_back.sv =====
// Back stage: line parse state and command decode at line end.
`timescale 1ns / 1ps
module atmc_back
    import atmc_pkg::*;
#(
    parameter int MAX_LINE = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tok_valid,
    input  t_token  i_tok,
    output logic    o_tok_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LINE);
    localparam logic [LEN_W:0]   MAX_TOT = (LEN_W + 1)'(MAX_LINE);
    localparam logic [LEN_W:0]   MIN_TOT = (LEN_W + 1)'(LINE_MIN_TOTAL);

    t_parse         r_st, n_st;
    t_parse         st_cr, st_b;
    logic [LEN_W:0] total;
    logic           hit;

    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = CH_A;
            2'd1:    c = CH_T;
            default: c = CH_PLUS;
        endcase
        return c;
    endfunction

    // Apply one line byte to the parse state
    function automatic t_parse feed(input t_parse s, input logic [7:0] b,
                                    input logic dig, input logic eq,
                                    input logic comma);
        t_parse      n;
        logic [19:0] acc;
        n   = s;
        acc = 20'(s.value) * 20'd10 + 20'(b[3:0]);
        if (s.len >= MAX_LEN) begin
            n.ovf = 1'b1;
        end else begin
            n.len = s.len + 1'b1;
        end
        if (!n.ovf) begin
            case (s.phase)
                PH_PREFIX: begin
                    if (b != prefix_char(s.len[1:0])) begin
                        n.prefix_ok = 1'b0;
                    end
                    if (s.len >= LEN_W'(2)) begin
                        n.phase = PH_NAME;
                    end
                end
                PH_NAME: begin
                    if (eq) begin
                        n.phase = PH_ARG_WAIT;
                    end else begin
                        n.name = {s.name[7:0], b};
                        if (s.ncount != 8'hFF) begin
                            n.ncount = s.ncount + 1'b1;
                        end
                    end
                end
                PH_ARG_WAIT, PH_ARG_IN: begin
                    if (comma) begin
                        if (s.phase == PH_ARG_IN) begin
                            n.phase = PH_ARG_DONE;
                        end
                    end else begin
                        n.phase = PH_ARG_IN;
                        if (dig) begin
                            n.value = (|acc[19:16]) ? 16'hFFFF : acc[15:0];
                        end else begin
                            n.bad = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        return n;
    endfunction

    // Next parse state: held CR first, then the byte itself
    always_comb begin
        st_cr = i_tok.feed_cr ? feed(r_st, CH_CR, 1'b0, 1'b0, 1'b0) : r_st;
        st_b  = i_tok.feed_b
              ? feed(st_cr, i_tok.data, i_tok.is_digit, i_tok.is_eq, i_tok.is_comma)
              : st_cr;
        n_st  = r_st;
        if (o_tok_pop) begin
            n_st = i_tok.eol ? PARSE_CLEAR : st_b;
        end
    end

    // Decode the finished line and drive the handshakes
    always_comb begin
        total       = {1'b0, r_st.len} + (LEN_W + 1)'(2);
        hit         = 1'b0;
        o_res.kind  = KIND_HEARTBEAT;
        o_res.power = '0;
        if (!r_st.ovf && total <= MAX_TOT && total >= MIN_TOT) begin
            if (total == MIN_TOT) begin
                hit = 1'b1;
            end else if (r_st.prefix_ok && r_st.ncount == 8'd2) begin
                hit = 1'b1;
                case (r_st.name)
                    NAME_GF: o_res.kind = KIND_FORWARD;
                    NAME_GB: o_res.kind = KIND_BACK;
                    NAME_GR: o_res.kind = KIND_RIGHT;
                    NAME_GL: o_res.kind = KIND_LEFT;
                    NAME_ST: o_res.kind = KIND_STOP;
                    default: hit = 1'b0;
                endcase
                if (o_res.kind != KIND_STOP && !r_st.bad &&
                    (r_st.phase == PH_ARG_IN || r_st.phase == PH_ARG_DONE)) begin
                    o_res.power = r_st.value;
                end
            end
        end
        o_tok_pop  = i_tok_valid && (!i_tok.eol || !i_res_full);
        o_res_push = o_tok_pop && i_tok.eol && hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= PARSE_CLEAR;
        end else begin
            r_st <= n_st;
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.len <= MAX_LEN)
        else $error("line length above limit");

    a_ovf_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.ovf |-> (r_st.len == MAX_LEN))
        else $error("overflow without full length");

    a_prefix_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.len < LEN_W'(3)) |-> (r_st.phase == PH_PREFIX && r_st.ncount == 8'd0))
        else $error("left prefix phase too early");

    a_clear_after_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_pop && i_tok.eol) |=> (r_st.len == '0 && r_st.phase == PH_PREFIX))
        else $error("state not cleared after line end");

endmodule
